// ===== sv/iou_pkg.sv =====
// ----------------------------------------------------------------------------
// iou_pkg
// Shared types and constants of the box match table.
// ----------------------------------------------------------------------------
package iou_pkg;

    localparam logic [1:0] OP_CLEAR = 2'd0;
    localparam logic [1:0] OP_LOAD  = 2'd1;
    localparam logic [1:0] OP_QUERY = 2'd2;

    localparam logic CFG_OVERLAP = 1'b0;
    localparam logic CFG_EXTEND  = 1'b1;

    localparam int CFG_W      = 11;
    localparam int OVERLAP_W  = 9;
    localparam int EXTEND_W   = 11;
    localparam int COORD_W    = 13;
    localparam int REF_XY_W   = 16;
    localparam int REF_WH_W   = 17;
    localparam int INTER_W    = 26;
    localparam int ENCL_W     = 34;

    localparam logic [OVERLAP_W-1:0] OVERLAP_RESET = 9'd128;
    localparam logic [EXTEND_W-1:0]  EXTEND_RESET  = 11'd256;

    typedef struct packed {
        logic signed [REF_XY_W-1:0] x;
        logic signed [REF_XY_W-1:0] y;
        logic [REF_WH_W-1:0]        w;
        logic [REF_WH_W-1:0]        h;
        logic [7:0]                 label;
        logic [7:0]                 direction;
        logic                       used;
    } entry_t;

    typedef struct packed {
        logic                valid;
        logic                found;
        logic [7:0]          label;
        logic                used;
        logic [7:0]          direction;
        logic [COORD_W-1:0]  x;
        logic [COORD_W-1:0]  y;
        logic [COORD_W-1:0]  w;
        logic [COORD_W-1:0]  h;
    } token_t;

endpackage

// ===== sv/iou_if.sv =====
// ----------------------------------------------------------------------------
// iou request and response channels
// Valid/ready channels carrying one box request or one match result.
// ----------------------------------------------------------------------------
interface iou_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  op;
    logic [12:0] box_x;
    logic [12:0] box_y;
    logic [12:0] box_w;
    logic [12:0] box_h;
    logic [7:0]  box_label;
    logic [7:0]  box_direction;
    logic        box_used;

    modport source (output valid, op, box_x, box_y, box_w, box_h, box_label,
                    box_direction, box_used, input ready);
    modport sink   (input valid, op, box_x, box_y, box_w, box_h, box_label,
                    box_direction, box_used, output ready);
endinterface

interface iou_rsp_if;
    logic       valid;
    logic       ready;
    logic       match_found;
    logic [7:0] out_label;
    logic       out_used;
    logic [7:0] out_direction;

    modport source (output valid, match_found, out_label, out_used, out_direction,
                    input ready);
    modport sink   (input valid, match_found, out_label, out_used, out_direction,
                    output ready);
endinterface

// ===== sv/iou_cell.sv =====
// ----------------------------------------------------------------------------
// iou_cell
// One table entry: compares the passing detection with its box, two stages.
// ----------------------------------------------------------------------------
module iou_cell
    import iou_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 active,
    input  logic [OVERLAP_W-1:0] ratio,
    input  logic                 we,
    input  entry_t               wr_entry,
    input  token_t               tok_in,
    output token_t               tok_out
);

    entry_t              entry_reg;
    token_t              tok_a_reg;
    logic [INTER_W-1:0]  inter_reg;
    logic [ENCL_W-1:0]   encl_reg;
    token_t              tok_b_reg;

    logic signed [19:0] dx0, dx1, dy0, dy1, rx0, rx1, ry0, ry1;
    logic signed [19:0] iw, ih, ew, eh;
    logic [INTER_W-1:0] inter;
    logic [ENCL_W-1:0]  encl;
    logic [42:0]        need;
    logic               hit;
    token_t             tok_b_next;

    always_comb
    begin
        dx0 = {7'b0, tok_in.x};
        dx1 = dx0 + {7'b0, tok_in.w};
        dy0 = {7'b0, tok_in.y};
        dy1 = dy0 + {7'b0, tok_in.h};
        rx0 = {{4{entry_reg.x[REF_XY_W-1]}}, entry_reg.x};
        rx1 = rx0 + {3'b0, entry_reg.w};
        ry0 = {{4{entry_reg.y[REF_XY_W-1]}}, entry_reg.y};
        ry1 = ry0 + {3'b0, entry_reg.h};
        iw  = ((dx1 < rx1) ? dx1 : rx1) - ((dx0 > rx0) ? dx0 : rx0);
        ih  = ((dy1 < ry1) ? dy1 : ry1) - ((dy0 > ry0) ? dy0 : ry0);
        ew  = ((dx1 > rx1) ? dx1 : rx1) - ((dx0 < rx0) ? dx0 : rx0);
        eh  = ((dy1 > ry1) ? dy1 : ry1) - ((dy0 < ry0) ? dy0 : ry0);
        // overlap never exceeds the detection size when positive
        inter = (iw > 20'sd0 && ih > 20'sd0) ? (INTER_W'(iw[12:0]) * INTER_W'(ih[12:0]))
                                              : '0;
        encl  = ENCL_W'(ew[16:0]) * ENCL_W'(eh[16:0]);
    end

    always_comb
    begin
        need = 43'(ratio) * 43'(encl_reg);
        hit  = (encl_reg != '0) && ({9'b0, inter_reg, 8'b0} >= need);
        tok_b_next = tok_a_reg;
        if (active && !tok_a_reg.found)
        begin
            tok_b_next.used      = entry_reg.used;
            tok_b_next.direction = entry_reg.direction;
            tok_b_next.found     = hit;
            tok_b_next.label     = hit ? entry_reg.label : 8'd0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            entry_reg <= wr_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_a_reg.valid <= 1'b0;
            tok_b_reg.valid <= 1'b0;
        end
        else
        begin
            tok_a_reg <= tok_in;
            tok_b_reg <= tok_b_next;
        end
    end

    always_ff @(posedge clk)
    begin
        inter_reg <= inter;
        encl_reg  <= encl;
    end

    assign tok_out = tok_b_reg;

endmodule

// ===== sv/iou_box_match_table.sv =====
// ----------------------------------------------------------------------------
// iou_box_match_table
// Reference box table with first-match overlap search over a chain of cells.
// ----------------------------------------------------------------------------
// query: request registered into the feed, then through the two registers of each
// cell in the chain; result offered once it leaves the last cell, held until transferred
// load: scale then write state; a load into a full table is dropped; clear and unused ops finish in idle
// one item at a time; next item taken in idle, for a query after its result has been transferred
// reset empties the table and loads the default ratios
module iou_box_match_table
    import iou_pkg::*;
#(
    parameter int TABLE_DEPTH = 16
)
(
    input  logic               clk,
    input  logic               rst_n,
    iou_req_if.sink            req,
    iou_rsp_if.source          rsp,
    input  logic               cfg_we,
    input  logic               cfg_index,
    input  logic [CFG_W-1:0]   cfg_data
);

    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCALE,
        ST_WRITE,
        ST_RUN,
        ST_OUT
    } state_t;

    state_t               state_reg;
    logic [CNT_W-1:0]     count_reg;
    logic [OVERLAP_W-1:0] overlap_reg;
    logic [EXTEND_W-1:0]  extend_reg;
    token_t               item_reg;
    token_t               feed_reg;
    logic [REF_WH_W-1:0]  ew_reg, eh_reg;
    token_t               res_reg;

    token_t               chain [TABLE_DEPTH+1];
    entry_t               wr_entry;
    logic                 req_xfer;
    logic signed [17:0]   dw, dh;
    logic signed [17:0]   hw, hh;
    logic [24:0]          sw, sh;
    token_t               feed_next;

    assign req.ready = (state_reg == ST_IDLE);
    assign req_xfer  = req.valid && req.ready;

    assign rsp.valid         = (state_reg == ST_OUT);
    assign rsp.match_found   = res_reg.found;
    assign rsp.out_label     = res_reg.label;
    assign rsp.out_used      = res_reg.used;
    assign rsp.out_direction = res_reg.direction;

    always_comb
    begin
        sw = 25'(item_reg.w) * 25'(extend_reg) + 25'd128;
        sh = 25'(item_reg.h) * 25'(extend_reg) + 25'd128;
        dw = $signed({1'b0, ew_reg}) - $signed({5'b0, item_reg.w});
        dh = $signed({1'b0, eh_reg}) - $signed({5'b0, item_reg.h});
        // arithmetic shift gives the floor of half the growth
        hw = dw >>> 1;
        hh = dh >>> 1;
        wr_entry.x         = REF_XY_W'($signed({5'b0, item_reg.x}) - hw);
        wr_entry.y         = REF_XY_W'($signed({5'b0, item_reg.y}) - hh);
        wr_entry.w         = ew_reg;
        wr_entry.h         = eh_reg;
        wr_entry.label     = item_reg.label;
        wr_entry.direction = item_reg.direction;
        wr_entry.used      = item_reg.used;

        feed_next.valid     = req_xfer && (req.op == OP_QUERY);
        feed_next.found     = 1'b0;
        feed_next.label     = req.box_label;
        feed_next.used      = req.box_used;
        feed_next.direction = req.box_direction;
        feed_next.x         = req.box_x;
        feed_next.y         = req.box_y;
        feed_next.w         = req.box_w;
        feed_next.h         = req.box_h;
    end

    assign chain[0] = feed_reg;

    for (genvar j = 0; j < TABLE_DEPTH; j++)
    begin : g_cell
        iou_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .active   (CNT_W'(j) < count_reg),
            .ratio    (overlap_reg),
            .we       ((state_reg == ST_WRITE) && (count_reg == CNT_W'(j))),
            .wr_entry (wr_entry),
            .tok_in   (chain[j]),
            .tok_out  (chain[j+1])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            count_reg      <= '0;
            overlap_reg    <= OVERLAP_RESET;
            extend_reg     <= EXTEND_RESET;
            feed_reg.valid <= 1'b0;
        end
        else
        begin
            feed_reg <= feed_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_OVERLAP: overlap_reg <= cfg_data[OVERLAP_W-1:0];
                    CFG_EXTEND:  extend_reg  <= cfg_data[EXTEND_W-1:0];
                    default:     ;
                endcase
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (req_xfer)
                    begin
                        case (req.op)
                            OP_CLEAR: count_reg <= '0;
                            OP_LOAD:
                            begin
                                if (count_reg < CNT_W'(TABLE_DEPTH))
                                begin
                                    state_reg <= ST_SCALE;
                                end
                            end
                            OP_QUERY: state_reg <= ST_RUN;
                            default:  ;
                        endcase
                    end
                end
                ST_SCALE: state_reg <= ST_WRITE;
                ST_WRITE:
                begin
                    count_reg <= count_reg + CNT_W'(1);
                    state_reg <= ST_IDLE;
                end
                ST_RUN:
                begin
                    if (chain[TABLE_DEPTH].valid)
                    begin
                        state_reg <= ST_OUT;
                    end
                end
                ST_OUT:
                begin
                    if (rsp.ready)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_xfer)
        begin
            item_reg <= feed_next;
        end
        if (state_reg == ST_SCALE)
        begin
            ew_reg <= sw[24:8];
            eh_reg <= sh[24:8];
        end
        if (chain[TABLE_DEPTH].valid)
        begin
            res_reg <= chain[TABLE_DEPTH];
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(TABLE_DEPTH))
        else $error("entry count beyond table depth");

    a_result_in_run: assert property (@(posedge clk) disable iff (!rst_n)
        chain[TABLE_DEPTH].valid |-> state_reg == ST_RUN)
        else $error("query left the chain outside a run");

    a_run_to_out: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RUN && chain[TABLE_DEPTH].valid) |=> rsp.valid)
        else $error("finished query not presented");
`endif

endmodule
